>>> hw/rtl/epd_pkg.sv
// Shared types and constants for the escaped packet deframer.
package epd_pkg;

  localparam logic [7:0] CH_ESCAPE = 8'h23;
  localparam logic [7:0] CH_START  = 8'h2B;
  localparam logic [7:0] CH_END    = 8'h2D;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_BYTE = 2'd1,
    EV_END  = 2'd2
  } event_e;

  typedef struct packed {
    logic       esc;
    logic [7:0] run_xor;
    logic [7:0] last;
  } state_t;

  typedef struct packed {
    event_e     ev;
    logic [7:0] byte_value;
    logic [5:0] byte_index;
    logic       packet_valid;
    logic [6:0] packet_length;
  } result_t;

endpackage

>>> hw/rtl/epd_if.sv
// Handshake channel interfaces for the deframer input and result streams.
interface epd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface epd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_res;
  logic [7:0] byte_value;
  logic [5:0] byte_index;
  logic       packet_valid;
  logic [6:0] packet_length;

  modport source (
    output valid, output event_res, output byte_value, output byte_index,
    output packet_valid, output packet_length, input ready
  );
  modport sink (
    input valid, input event_res, input byte_value, input byte_index,
    input packet_valid, input packet_length, output ready
  );
endinterface

>>> hw/rtl/epd_decode.sv
// Per-byte decode: escape handling, packet framing, checksum and result.
module epd_decode import epd_pkg::*; #(
  parameter int MAX_PACKET_BYTES = 64,
  parameter int CntW = $clog2(MAX_PACKET_BYTES + 1)
) (
  input  logic [7:0]      data_byte_i,
  input  state_t          state_i,
  input  logic [CntW-1:0] cnt_i,
  output state_t          state_o,
  output logic [CntW-1:0] cnt_o,
  output result_t         res_o
);

  logic       store;
  logic [7:0] cnt8;

  assign cnt8 = 8'(cnt_i);

  always_comb begin
    state_o = state_i;
    cnt_o   = cnt_i;
    res_o   = '0;
    res_o.ev = EV_NONE;
    store   = 1'b0;
    if (!state_i.esc) begin
      case (data_byte_i)
        CH_ESCAPE: begin
          state_o.esc = 1'b1;
        end
        CH_START: begin
          cnt_o           = '0;
          state_o.run_xor = '0;
          state_o.last    = '0;
        end
        CH_END: begin
          res_o.ev            = EV_END;
          res_o.packet_length = cnt8[6:0];
          res_o.packet_valid  = (cnt_i != '0) &&
                                (~(state_i.run_xor ^ state_i.last) == state_i.last);
        end
        default: begin
          store = 1'b1;
        end
      endcase
    end else begin
      state_o.esc = 1'b0;
      store       = 1'b1;
    end
    if (store && (cnt_i < CntW'(MAX_PACKET_BYTES))) begin
      res_o.ev         = EV_BYTE;
      res_o.byte_value = data_byte_i;
      res_o.byte_index = cnt8[5:0];
      state_o.run_xor  = state_i.run_xor ^ data_byte_i;
      state_o.last     = data_byte_i;
      cnt_o            = cnt_i + CntW'(1);
    end
  end

endmodule

>>> hw/rtl/escaped_packet_deframer.sv
// Top level of the escaped packet deframer.
//
// Usage: bytes arrive on in_i (valid/ready); every accepted request yields
// exactly one result on out_o, in order. A result carries event_res: none
// (escape mark, start mark or dropped byte), a stored payload byte with its
// value and index, or an end of packet with its checksum verdict and length.
// '#' escapes the next byte, '+' clears the packet, '-' reports it; a packet
// is valid when the inverted XOR of all stored bytes but the last equals the
// last one.
// Flow: an accepted request sits in the input register, is decoded into the
// result register, and can then be taken from out_o. Throughput: one byte per
// cycle while out_o.ready stays high, set by the combinational decode between
// the two registers.
// Stall: when out_o.ready is low the result register holds, the input
// register fills, and then in_i.ready drops; no request is lost.
// Reset: rst_ni clears escape state, count, checksum and both valid flags.
module escaped_packet_deframer import epd_pkg::*; #(
  parameter int MAX_PACKET_BYTES = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  epd_in_if.sink    in_i,
  epd_out_if.source out_o
);

  localparam int CntW = $clog2(MAX_PACKET_BYTES + 1);

  logic            in_valid_q;
  logic [7:0]      in_byte_q;
  logic            out_valid_q;
  result_t         res_q;
  result_t         res_d;
  state_t          state_q;
  state_t          state_d;
  logic [CntW-1:0] cnt_q;
  logic [CntW-1:0] cnt_d;
  logic            adv;

  assign adv        = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || adv;

  epd_decode #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES),
    .CntW            (CntW)
  ) u_decode (
    .data_byte_i(in_byte_q),
    .state_i    (state_q),
    .cnt_i      (cnt_q),
    .state_o    (state_d),
    .cnt_o      (cnt_d),
    .res_o      (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
      cnt_q       <= '0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
        cnt_q       <= cnt_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_byte_q <= in_i.data_byte;
    end
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.event_res     = res_q.ev;
  assign out_o.byte_value    = res_q.byte_value;
  assign out_o.byte_index    = res_q.byte_index;
  assign out_o.packet_valid  = res_q.packet_valid;
  assign out_o.packet_length = res_q.packet_length;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MAX_PACKET_BYTES))
    else $error("stored count above capacity");

  a_valid_needs_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && res_d.packet_valid |-> cnt_q != '0)
    else $error("valid packet reported with no stored bytes");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> in_valid_q && out_valid_q && !out_o.ready)
    else $error("input stalled without a full pipeline");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(cnt_q) && $stable(state_q))
    else $error("state changed without a request advancing");

endmodule
